// File: rtl/tgb_pkg.sv
// Package: shared constants and command/status codes for the text gap buffer.
package tgb_pkg;

    localparam int DEFAULT_CAPACITY = 1024;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic [2:0] CMD_INSERT    = 3'd0;
    localparam logic [2:0] CMD_BACKSPACE = 3'd1;
    localparam logic [2:0] CMD_LEFT      = 3'd2;
    localparam logic [2:0] CMD_RIGHT     = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

endpackage

// File: rtl/text_gap_buffer_top.sv
// Text gap buffer: command decode, gap-move sequencer and text memory.
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+----------------------
//  input   | cmd, ch, distance, position               | in  | in_valid / in_ready
//  output  | status, read_char, moved, before_len,     | out | out_valid / out_ready
//          | after_len, total_lines, cursor_line       |     |
//
// Insert, unused codes and refused commands go straight to the finishing step;
// backspace and read pass first through a memory-read step, and a move through
// the move step (one character per cycle through the text memory, then a drain of the last write).
// One transaction is in work at a time; a new one is taken while the last result
// waits in the output register. Reset clears counts and control only; the text
// memory is not cleared. A stalled output holds the finishing step until taken.
module text_gap_buffer_top
    import tgb_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    cmd,
    input  logic [7:0]    ch,
    input  logic [CW-1:0] distance,
    input  logic [AW-1:0] position,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [7:0]    read_char,
    output logic [CW-1:0] moved,
    output logic [CW-1:0] before_len,
    output logic [CW-1:0] after_len,
    output logic [CW-1:0] total_lines,
    output logic [CW-1:0] cursor_line
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BSW,
        S_RDW,
        S_MOVE,
        S_FIN
    } state_t;

    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    state_t        state_reg, state_next;
    logic [CW-1:0] front_reg, front_next;
    logic [CW-1:0] back_reg, back_next;
    logic [CW-1:0] nl_tot_reg, nl_tot_next;
    logic [CW-1:0] nl_front_reg, nl_front_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          dir_reg, dir_next;
    logic          pend_reg, pend_next;
    logic [1:0]    st_reg, st_next;
    logic [7:0]    rchar_reg, rchar_next;
    logic [CW-1:0] moved_reg, moved_next;

    logic          o_valid_reg, o_valid_next;
    logic [1:0]    o_status_reg, o_status_next;
    logic [7:0]    o_rchar_reg, o_rchar_next;
    logic [CW-1:0] o_moved_reg, o_moved_next;
    logic [CW-1:0] o_before_reg, o_before_next;
    logic [CW-1:0] o_after_reg, o_after_next;
    logic [CW-1:0] o_tot_reg, o_tot_next;
    logic [CW-1:0] o_cur_reg, o_cur_next;

    logic [7:0]    mem [CAPACITY];
    logic [7:0]    rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;

    logic [CW-1:0] used;
    logic [CW-1:0] front_m1;
    logic [CW-1:0] back_base;
    logic [CW-1:0] pos_ext;

    assign used      = front_reg + back_reg;
    assign front_m1  = front_reg - CW'(1);
    assign back_base = CAP - back_reg;
    assign pos_ext   = CW'(position);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        nl_tot_next   = nl_tot_reg;
        nl_front_next = nl_front_reg;
        rem_next      = rem_reg;
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        dir_next      = dir_reg;
        pend_next     = 1'b0;
        st_next       = st_reg;
        rchar_next    = rchar_reg;
        moved_next    = moved_reg;
        o_valid_next  = o_valid_reg;
        o_status_next = o_status_reg;
        o_rchar_next  = o_rchar_reg;
        o_moved_next  = o_moved_reg;
        o_before_next = o_before_reg;
        o_after_next  = o_after_reg;
        o_tot_next    = o_tot_reg;
        o_cur_next    = o_cur_reg;
        mem_we        = 1'b0;
        mem_waddr     = wp_reg;
        mem_wdata     = rdata_reg;
        mem_raddr     = rp_reg;

        if (o_valid_reg && out_ready)
        begin
            o_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    st_next    = ST_OK;
                    rchar_next = 8'd0;
                    moved_next = '0;
                    state_next = S_FIN;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (used >= CAP)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = front_reg[AW-1:0];
                                mem_wdata  = ch;
                                front_next = front_reg + CW'(1);
                                if (ch == NEWLINE_CHAR)
                                begin
                                    nl_tot_next   = nl_tot_reg + CW'(1);
                                    nl_front_next = nl_front_reg + CW'(1);
                                end
                            end
                        end
                        CMD_BACKSPACE:
                        begin
                            if (front_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_raddr  = front_m1[AW-1:0];
                                front_next = front_m1;
                                state_next = S_BSW;
                            end
                        end
                        CMD_LEFT:
                        begin
                            if (front_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                moved_next = (distance < front_reg) ? distance : front_reg;
                                rem_next   = (distance < front_reg) ? distance : front_reg;
                                rp_next    = front_m1[AW-1:0];
                                wp_next    = AW'(back_base - CW'(1));
                                dir_next   = 1'b0;
                                state_next = S_MOVE;
                            end
                        end
                        CMD_RIGHT:
                        begin
                            if (back_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                moved_next = (distance < back_reg) ? distance : back_reg;
                                rem_next   = (distance < back_reg) ? distance : back_reg;
                                rp_next    = back_base[AW-1:0];
                                wp_next    = front_reg[AW-1:0];
                                dir_next   = 1'b1;
                                state_next = S_MOVE;
                            end
                        end
                        CMD_READ:
                        begin
                            if (pos_ext >= used)
                            begin
                                st_next = ST_RANGE;
                            end
                            else
                            begin
                                // back half sits past the gap
                                if (pos_ext < front_reg)
                                begin
                                    mem_raddr = position;
                                end
                                else
                                begin
                                    mem_raddr = AW'(pos_ext + (CAP - used));
                                end
                                state_next = S_RDW;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BSW:
            begin
                if (rdata_reg == NEWLINE_CHAR)
                begin
                    if (nl_tot_reg != '0)
                    begin
                        nl_tot_next = nl_tot_reg - CW'(1);
                    end
                    if (nl_front_reg != '0)
                    begin
                        nl_front_next = nl_front_reg - CW'(1);
                    end
                end
                state_next = S_FIN;
            end
            S_RDW:
            begin
                rchar_next = rdata_reg;
                state_next = S_FIN;
            end
            S_MOVE:
            begin
                // read of the next character overlaps the write of the last
                if (rem_reg != '0)
                begin
                    rem_next  = rem_reg - CW'(1);
                    rp_next   = dir_reg ? rp_reg + AW'(1) : rp_reg - AW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    mem_we  = 1'b1;
                    wp_next = dir_reg ? wp_reg + AW'(1) : wp_reg - AW'(1);
                    if (dir_reg)
                    begin
                        front_next = front_reg + CW'(1);
                        back_next  = back_reg - CW'(1);
                        if (rdata_reg == NEWLINE_CHAR)
                        begin
                            nl_front_next = nl_front_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        front_next = front_reg - CW'(1);
                        back_next  = back_reg + CW'(1);
                        if (rdata_reg == NEWLINE_CHAR && nl_front_reg != '0)
                        begin
                            nl_front_next = nl_front_reg - CW'(1);
                        end
                    end
                end
                if (rem_reg == '0 && !pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!o_valid_reg || out_ready)
                begin
                    o_valid_next  = 1'b1;
                    o_status_next = st_reg;
                    o_rchar_next  = rchar_reg;
                    o_moved_next  = moved_reg;
                    o_before_next = front_reg;
                    o_after_next  = back_reg;
                    o_tot_next    = nl_tot_reg;
                    o_cur_next    = nl_front_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            back_reg     <= '0;
            nl_tot_reg   <= '0;
            nl_front_reg <= '0;
            rem_reg      <= '0;
            rp_reg       <= '0;
            wp_reg       <= '0;
            dir_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            st_reg       <= ST_OK;
            rchar_reg    <= 8'd0;
            moved_reg    <= '0;
            o_valid_reg  <= 1'b0;
            o_status_reg <= ST_OK;
            o_rchar_reg  <= 8'd0;
            o_moved_reg  <= '0;
            o_before_reg <= '0;
            o_after_reg  <= '0;
            o_tot_reg    <= '0;
            o_cur_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            back_reg     <= back_next;
            nl_tot_reg   <= nl_tot_next;
            nl_front_reg <= nl_front_next;
            rem_reg      <= rem_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            dir_reg      <= dir_next;
            pend_reg     <= pend_next;
            st_reg       <= st_next;
            rchar_reg    <= rchar_next;
            moved_reg    <= moved_next;
            o_valid_reg  <= o_valid_next;
            o_status_reg <= o_status_next;
            o_rchar_reg  <= o_rchar_next;
            o_moved_reg  <= o_moved_next;
            o_before_reg <= o_before_next;
            o_after_reg  <= o_after_next;
            o_tot_reg    <= o_tot_next;
            o_cur_reg    <= o_cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = o_valid_reg;
    assign status      = o_status_reg;
    assign read_char   = o_rchar_reg;
    assign moved       = o_moved_reg;
    assign before_len  = o_before_reg;
    assign after_len   = o_after_reg;
    assign total_lines = o_tot_reg;
    assign cursor_line = o_cur_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, front_reg} + {1'b0, back_reg}) <= {1'b0, CAP})
        else $error("text length exceeds capacity");

    a_line_order: assert property (@(posedge clk) disable iff (!rst_n)
        nl_front_reg <= nl_tot_reg)
        else $error("cursor line beyond total lines");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while one is in work");

    a_move_status: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_moved_reg != '0 |-> o_status_reg == ST_OK)
        else $error("nonzero move reported with error status");

endmodule

// File: dv/text_gap_buffer_top_tb.sv
// Testbench for text_gap_buffer_top: directed and random edits checked against a predictor.
`timescale 1ns / 1ps

module text_gap_buffer_top_tb;
    import tgb_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    typedef struct packed {
        logic [1:0]    status;
        logic [7:0]    read_char;
        logic [CW-1:0] moved;
        logic [CW-1:0] before_len;
        logic [CW-1:0] after_len;
        logic [CW-1:0] total_lines;
        logic [CW-1:0] cursor_line;
    } gap_result_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [2:0]    cmd;
    logic [7:0]    ch;
    logic [CW-1:0] distance;
    logic [AW-1:0] position;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [1:0]    status;
    logic [7:0]    read_char;
    logic [CW-1:0] moved;
    logic [CW-1:0] before_len;
    logic [CW-1:0] after_len;
    logic [CW-1:0] total_lines;
    logic [CW-1:0] cursor_line;

    // shadow copy of the editor state
    logic [7:0]  shadow_text [CAPACITY];
    int unsigned shadow_front;
    int unsigned shadow_back;
    int unsigned shadow_nl_total;
    int unsigned shadow_nl_front;

    gap_result_t predicted_results [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned full_seen;
    int unsigned range_seen;
    int unsigned longest_move;

    text_gap_buffer_top #(.CAPACITY(CAPACITY)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .ch          (ch),
        .distance    (distance),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_char   (read_char),
        .moved       (moved),
        .before_len  (before_len),
        .after_len   (after_len),
        .total_lines (total_lines),
        .cursor_line (cursor_line)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic gap_result_t predict_edit(logic [2:0] op, logic [7:0] c,
                                                 logic [CW-1:0] span, logic [AW-1:0] pos);
        gap_result_t r;
        int unsigned n;
        int unsigned idx;
        logic [7:0]  b;
        r = '0;
        case (op)
            CMD_INSERT:
            begin
                if (shadow_front + shadow_back >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_text[AW'(shadow_front)] = c;
                    shadow_front++;
                    if (c == NEWLINE_CHAR)
                    begin
                        shadow_nl_total++;
                        shadow_nl_front++;
                    end
                end
            end
            CMD_BACKSPACE:
            begin
                if (shadow_front == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    shadow_front--;
                    if (shadow_text[AW'(shadow_front)] == NEWLINE_CHAR)
                    begin
                        if (shadow_nl_total > 0) shadow_nl_total--;
                        if (shadow_nl_front > 0) shadow_nl_front--;
                    end
                end
            end
            CMD_LEFT:
            begin
                if (shadow_front == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    n = (span < shadow_front) ? span : shadow_front;
                    r.moved = CW'(n);
                    repeat (n)
                    begin
                        shadow_front--;
                        shadow_back++;
                        b = shadow_text[AW'(shadow_front)];
                        shadow_text[AW'(CAPACITY - shadow_back)] = b;
                        if (b == NEWLINE_CHAR && shadow_nl_front > 0) shadow_nl_front--;
                    end
                end
            end
            CMD_RIGHT:
            begin
                if (shadow_back == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    n = (span < shadow_back) ? span : shadow_back;
                    r.moved = CW'(n);
                    repeat (n)
                    begin
                        b = shadow_text[AW'(CAPACITY - shadow_back)];
                        shadow_text[AW'(shadow_front)] = b;
                        shadow_front++;
                        shadow_back--;
                        if (b == NEWLINE_CHAR) shadow_nl_front++;
                    end
                end
            end
            CMD_READ:
            begin
                if (pos >= shadow_front + shadow_back)
                    r.status = ST_RANGE;
                else if (pos < shadow_front)
                    r.read_char = shadow_text[pos];
                else
                begin
                    idx = CAPACITY - shadow_back + (pos - shadow_front);
                    if (idx < CAPACITY) r.read_char = shadow_text[AW'(idx)];
                end
            end
            default: ;
        endcase
        r.before_len  = CW'(shadow_front);
        r.after_len   = CW'(shadow_back);
        r.total_lines = CW'(shadow_nl_total);
        r.cursor_line = CW'(shadow_nl_front);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [CW-1:0] got, logic [CW-1:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic [2:0] op, logic [7:0] c, logic [CW-1:0] span,
                             logic [AW-1:0] pos);
        gap_result_t r;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        ch       <= c;
        distance <= span;
        position <= pos;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = predict_edit(op, c, span, pos);
        if (r.status == ST_FULL) full_seen++;
        if (r.status == ST_RANGE) range_seen++;
        if (r.moved > longest_move) longest_move = 32'(r.moved);
        predicted_results = {predicted_results, r};
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        gap_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                e = predicted_results.pop_front();
                results_checked++;
                check_field("status", CW'(status), CW'(e.status));
                check_field("read_char", CW'(read_char), CW'(e.read_char));
                check_field("moved", moved, e.moved);
                check_field("before_len", before_len, e.before_len);
                check_field("after_len", after_len, e.after_len);
                check_field("total_lines", total_lines, e.total_lines);
                check_field("cursor_line", cursor_line, e.cursor_line);
            end
        end
    end

    task automatic test_empty_buffer();
        send_item(CMD_READ, 8'h00, '0, '0);
        send_item(CMD_BACKSPACE, 8'hFF, '0, '0);
        send_item(CMD_LEFT, 8'h00, 11'd5, '0);
        send_item(CMD_RIGHT, 8'h00, 11'd5, '0);
        send_item(CMD_LEFT, 8'h00, 11'd0, '0);
    endtask

    task automatic test_directed_edits();
        send_item(CMD_INSERT, 8'h00, '0, '0);
        send_item(CMD_INSERT, NEWLINE_CHAR, '0, '0);
        send_item(CMD_INSERT, 8'hFF, '0, '0);
        send_item(CMD_INSERT, 8'h61, '0, '0);
        send_item(CMD_LEFT, 8'h00, 11'd0, '0);
        send_item(CMD_LEFT, 8'h00, 11'd2, '0);
        send_item(CMD_READ, 8'h00, '0, 10'd0);
        send_item(CMD_READ, 8'h00, '0, 10'd2);
        send_item(CMD_READ, 8'h00, '0, 10'd3);
        send_item(CMD_READ, 8'h00, '0, 10'd4);
        send_item(CMD_READ, 8'h00, '0, 10'd1023);
        send_item(CMD_RIGHT, 8'h00, 11'd1024, '0);
        send_item(CMD_RIGHT, 8'h00, 11'd1, '0);
        send_item(CMD_LEFT, 8'h00, 11'd1024, '0);
        send_item(CMD_RIGHT, 8'h00, 11'd2, '0);
        send_item(CMD_BACKSPACE, 8'h00, '0, '0);
        send_item(CMD_SPARE_A, 8'hA5, 11'd1024, 10'd1023);
        send_item(CMD_SPARE_B, 8'h5A, 11'd7, 10'd1);
        send_item(CMD_SPARE_C, 8'hFF, 11'd0, 10'd512);
        send_item(CMD_BACKSPACE, 8'h00, '0, '0);
        send_item(CMD_INSERT, NEWLINE_CHAR, '0, '0);
        send_item(CMD_RIGHT, 8'h00, 11'd1024, '0);
    endtask

    task automatic test_random_edits(int unsigned count, int unsigned idle_pct,
                                     int unsigned stall_pct);
        int unsigned len;
        int unsigned pick;
        int unsigned sel;
        logic [2:0]    op;
        logic [7:0]    c;
        logic [CW-1:0] span;
        logic [AW-1:0] pos;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            len  = shadow_front + shadow_back;
            pick = $urandom_range(99);
            if (pick < ((len > 160) ? 20 : 42))
                op = CMD_INSERT;
            else if (pick < 57)
                op = CMD_BACKSPACE;
            else if (pick < 69)
                op = CMD_LEFT;
            else if (pick < 81)
                op = CMD_RIGHT;
            else if (pick < 97)
                op = CMD_READ;
            else
                op = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
            c = ($urandom_range(5) == 0) ? NEWLINE_CHAR : 8'($urandom_range(255));
            sel = $urandom_range(9);
            if (sel < 7)
                span = CW'($urandom_range(8));
            else if (sel < 9)
                span = CW'($urandom_range(len));
            else
                span = CW'(CAPACITY);
            if ($urandom_range(3) == 0 || len > CAPACITY - 1)
                pos = AW'($urandom_range(CAPACITY - 1));
            else
                pos = AW'($urandom_range(len));
            send_item(op, c, span, pos);
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        repeat (12)
            send_item(3'($urandom_range(CMD_INSERT, CMD_READ)), 8'($urandom_range(255)),
                      CW'($urandom_range(3)), AW'($urandom_range(20)));
    endtask

    task automatic test_fill_to_capacity();
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        while (shadow_front + shadow_back < CAPACITY)
            send_item(CMD_INSERT,
                      ($urandom_range(7) == 0) ? NEWLINE_CHAR : 8'($urandom_range(255)),
                      '0, '0);
        send_item(CMD_INSERT, 8'h41, '0, '0);
        send_item(CMD_READ, 8'h00, '0, 10'd1023);
        send_item(CMD_READ, 8'h00, '0, 10'd0);
        send_item(CMD_LEFT, 8'h00, 11'd1024, '0);
        send_item(CMD_INSERT, NEWLINE_CHAR, '0, '0);
        send_item(CMD_READ, 8'h00, '0, 10'd1023);
        send_item(CMD_LEFT, 8'h00, 11'd3, '0);
        send_item(CMD_RIGHT, 8'h00, 11'd1024, '0);
        send_item(CMD_RIGHT, 8'h00, 11'd1, '0);
        send_item(CMD_LEFT, 8'h00, 11'd1000, '0);
        repeat (20)
            send_item(CMD_READ, 8'h00, '0, AW'($urandom_range(CAPACITY - 1)));
        repeat (6)
            send_item(CMD_BACKSPACE, 8'h00, '0, '0);
        send_item(CMD_RIGHT, 8'h00, 11'd1024, '0);
        send_item(CMD_LEFT, 8'h00, 11'd1024, '0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_INSERT;
        ch = '0;
        distance = '0;
        position = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        mismatch_count = 0;
        results_checked = 0;
        full_seen = 0;
        range_seen = 0;
        longest_move = 0;
        shadow_front = 0;
        shadow_back = 0;
        shadow_nl_total = 0;
        shadow_nl_front = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_buffer();
        test_directed_edits();
        test_random_edits(145, 0, 0);
        test_random_edits(145, 55, 0);
        test_output_backpressure();
        test_random_edits(145, 0, 55);
        test_random_edits(145, 16, 16);
        test_fill_to_capacity();

        in_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (predicted_results.size() != 0)
            report_mismatch("transactions left without a result");
        $display("Covered empty, directed, random and full-buffer edits: %0d results checked",
                 results_checked);
        $display("Full inserts %0d, out-of-range reads %0d, longest move %0d, mismatches %0d",
                 full_seen, range_seen, longest_move, mismatch_count);
        if (mismatch_count == 0)
            $display("text_gap_buffer_top_tb: done, clean");
        else
            $display("text_gap_buffer_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #64_000_000;
        $display("Timeout with %0d transactions outstanding", predicted_results.size());
        $display("text_gap_buffer_top_tb: done, errors");
        $finish;
    end

endmodule

// File: text_gap_buffer_top.f
rtl/tgb_pkg.sv
rtl/text_gap_buffer_top.sv
dv/text_gap_buffer_top_tb.sv
